### src/amu_pkg.sv
// Package for the affine matrix unit: item structs, operation codes and
// the fixed-point fraction width. Used by affine_matrix_unit; amu_mac and amu_div are standalone.
package amu_pkg;

    localparam int FracBits = 10;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_MUL    = 3'd1,
        OP_SCALE  = 3'd2,
        OP_INVERT = 3'd3,
        OP_XFORM  = 3'd4,
        OP_SCALEP = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] operand_xx;
        logic signed [31:0] operand_xy;
        logic signed [31:0] operand_xz;
        logic signed [31:0] operand_yx;
        logic signed [31:0] operand_yy;
        logic signed [31:0] operand_yz;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] scale_factor;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_xx;
        logic signed [31:0] result_xy;
        logic signed [31:0] result_xz;
        logic signed [31:0] result_yx;
        logic signed [31:0] result_yy;
        logic signed [31:0] result_yz;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               singular;
    } out_item_t;

endpackage

### src/amu_div.sv
// Radix-2 restoring divider for 66-bit signed numerators by 32-bit signed
// divisors, one quotient bit per cycle, truncating toward zero. Standalone.
module amu_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [65:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic        [31:0] quot
);
    logic [65:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [32:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic [65:0] qneg;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = '0;
        if (start) begin
            q_next = num[65] ? 66'(-num) : num;
            d_next = den[31] ? 33'(-{den[31], den}) : {1'b0, den};
            neg_next = num[65] ^ den[31];
            r_next = '0;
            cnt_next = 7'd66;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            trial = {r_reg, q_reg[65]} - {1'b0, d_reg};
            if (!trial[33]) begin
                r_next = trial[32:0];
                q_next = {q_reg[64:0], 1'b1};
            end else begin
                r_next = {r_reg[31:0], q_reg[65]};
                q_next = {q_reg[64:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    assign qneg = neg_reg ? 66'(-q_reg) : q_reg;
    assign quot = qneg[31:0];
    assign done = done_reg;
endmodule

### src/amu_mac.sv
// Shared multiply-accumulate unit: one 32x32 signed product per cycle,
// registered, then added into a 66-bit accumulator. Standalone.
module amu_mac (
    input  logic               aclk,
    input  logic               clear,
    input  logic               valid,
    input  logic               sub,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [65:0] acc
);
    logic signed [63:0] prod_reg;
    logic               pv_reg;
    logic               psub_reg;
    logic signed [65:0] acc_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
        pv_reg <= valid;
        psub_reg <= sub;
        if (clear) begin
            acc_reg <= '0;
        end else if (pv_reg) begin
            acc_reg <= psub_reg ? acc_reg - 66'(prod_reg) : acc_reg + 66'(prod_reg);
        end
    end

    assign acc = acc_reg;
endmodule

### src/affine_matrix_unit.sv
// Affine matrix unit top level: sequencer, held matrix and output register.
// Depends on amu_pkg, amu_mac and amu_div.
//
// The block holds a 2x3 Q21.10 affine matrix and runs one operation per item
// on a single shared 32x32 multiplier with a 66-bit accumulator. Load and the
// unused codes run no dot product, point scaling and point transform run two,
// matrix scaling and multiply six. Invert runs three dot products for the
// determinant and two numerators, then the one-bit-per-cycle divider for six
// quotients; a zero determinant skips the divider. The block is ready again in
// the cycle in which it presents a result. A result that is not taken waits in
// the output register while the next item is worked on; that item then waits
// until the result is taken.
module affine_matrix_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  amu_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output amu_pkg::out_item_t  m_data
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MAC  = 6'b000010,
        ST_WAIT = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_DWT  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    amu_pkg::in_item_t  item_reg;
    logic signed [31:0] h_reg [6];
    logic signed [31:0] r_reg [6];
    logic signed [31:0] px_reg, py_reg;
    logic signed [31:0] det_reg;
    logic signed [65:0] nums_reg [6];
    logic [2:0]         idx_reg, idx_next;
    logic               term_reg, term_next;
    logic               sing_reg;
    amu_pkg::out_item_t out_reg;
    logic               m_valid_reg;

    logic               mclear, mvalid, msub;
    logic signed [31:0] ma, mb;
    logic signed [65:0] acc;
    logic               dstart, ddone;
    logic [31:0]        dq;
    logic [2:0]         wcnt_reg;
    logic [2:0]         njobs;
    logic signed [31:0] addz;
    logic signed [65:0] sh;
    amu_pkg::op_t       op;

    assign op = amu_pkg::op_t'(item_reg.operation);

    amu_mac u_mac (
        .aclk(aclk), .clear(mclear), .valid(mvalid), .sub(msub),
        .a(ma), .b(mb), .acc(acc)
    );

    amu_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart),
        .num(nums_reg[idx_reg]), .den(det_reg), .done(ddone), .quot(dq)
    );

    // Jobs per operation: idx counts result words, term the two products.
    always_comb begin
        case (op)
            amu_pkg::OP_MUL:    njobs = 3'd6;
            amu_pkg::OP_SCALE:  njobs = 3'd6;
            amu_pkg::OP_INVERT: njobs = 3'd3;
            amu_pkg::OP_XFORM:  njobs = 3'd2;
            amu_pkg::OP_SCALEP: njobs = 3'd2;
            default:            njobs = 3'd0;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        ma = '0;
        mb = '0;
        msub = 1'b0;
        addz = '0;
        case (op)
            amu_pkg::OP_MUL: begin
                ma = term_reg ? h_reg[{idx_reg >= 3'd3 ? 3'd4 : 3'd1}]
                              : h_reg[{idx_reg >= 3'd3 ? 3'd3 : 3'd0}];
                case (idx_reg)
                    3'd0, 3'd3: mb = term_reg ? item_reg.operand_yx : item_reg.operand_xx;
                    3'd1, 3'd4: mb = term_reg ? item_reg.operand_yy : item_reg.operand_xy;
                    default:    mb = term_reg ? item_reg.operand_yz : item_reg.operand_xz;
                endcase
                if (idx_reg == 3'd2) addz = h_reg[2];
                if (idx_reg == 3'd5) addz = h_reg[5];
            end
            amu_pkg::OP_SCALE: begin
                ma = term_reg ? 32'sd0 : item_reg.scale_factor;
                mb = h_reg[idx_reg];
            end
            amu_pkg::OP_INVERT: begin
                case (idx_reg)
                    3'd0: begin
                        ma = term_reg ? h_reg[1] : h_reg[0];
                        mb = term_reg ? h_reg[3] : h_reg[4];
                        msub = term_reg;
                    end
                    3'd1: begin
                        ma = term_reg ? h_reg[2] : h_reg[1];
                        mb = term_reg ? h_reg[4] : h_reg[5];
                        msub = term_reg;
                    end
                    default: begin
                        ma = term_reg ? h_reg[0] : h_reg[2];
                        mb = term_reg ? h_reg[5] : h_reg[3];
                        msub = term_reg;
                    end
                endcase
            end
            amu_pkg::OP_XFORM: begin
                ma = term_reg ? h_reg[idx_reg == 3'd0 ? 3'd1 : 3'd4]
                              : h_reg[idx_reg == 3'd0 ? 3'd0 : 3'd3];
                mb = term_reg ? py_reg : px_reg;
                addz = h_reg[idx_reg == 3'd0 ? 3'd2 : 3'd5];
            end
            amu_pkg::OP_SCALEP: begin
                ma = term_reg ? 32'sd0 : item_reg.scale_factor;
                mb = idx_reg == 3'd0 ? px_reg : py_reg;
            end
            default: begin
                ma = '0;
            end
        endcase
    end

    assign sh = acc >>> amu_pkg::FracBits;
    assign mclear = (state_reg == ST_IDLE) || (state_reg == ST_WAIT && wcnt_reg == 3'd0);
    assign mvalid = (state_reg == ST_MAC);
    assign dstart = (state_reg == ST_DIV);

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        term_next = term_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MAC;
                    idx_next = '0;
                    term_next = 1'b0;
                end
            end
            ST_MAC: begin
                if (njobs == 3'd0) begin
                    state_next = ST_OUT;
                end else begin
                    term_next = ~term_reg;
                    if (term_reg) state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (wcnt_reg == 3'd0) begin
                    if (idx_reg == njobs - 3'd1) begin
                        idx_next = '0;
                        state_next = (op == amu_pkg::OP_INVERT) ? ST_DIV : ST_OUT;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                        state_next = ST_MAC;
                    end
                end
            end
            ST_DIV: begin
                // A zero determinant skips the divider straight to the result.
                if (idx_reg == 3'd0 && det_reg == 32'sd0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_DWT;
                end
            end
            ST_DWT: begin
                if (ddone) begin
                    if (idx_reg == 3'd5) begin
                        state_next = ST_OUT;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            term_reg <= 1'b0;
            wcnt_reg <= '0;
            m_valid_reg <= 1'b0;
            sing_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                h_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            term_reg <= term_next;
            if (state_reg == ST_IDLE && s_valid) begin
                item_reg <= s_data;
                px_reg <= s_data.point_x;
                py_reg <= s_data.point_y;
                sing_reg <= 1'b0;
                for (int i = 0; i < 6; i++) begin
                    r_reg[i] <= h_reg[i];
                end
            end
            if (state_reg == ST_MAC && term_reg) wcnt_reg <= 3'd2;
            if (state_reg == ST_WAIT) begin
                if (wcnt_reg != 3'd0) begin
                    wcnt_reg <= wcnt_reg - 3'd1;
                end else if (op == amu_pkg::OP_INVERT) begin
                    case (idx_reg)
                        3'd0: begin
                            det_reg <= sh[31:0];
                            nums_reg[0] <= 66'(h_reg[4]) <<< amu_pkg::FracBits;
                            nums_reg[1] <= -(66'(h_reg[1]) <<< amu_pkg::FracBits);
                            nums_reg[3] <= -(66'(h_reg[3]) <<< amu_pkg::FracBits);
                            nums_reg[4] <= 66'(h_reg[0]) <<< amu_pkg::FracBits;
                        end
                        3'd1: nums_reg[2] <= acc;
                        default: nums_reg[5] <= acc;
                    endcase
                end else begin
                    r_reg[idx_reg] <= sh[31:0] + addz;
                end
            end
            if (state_reg == ST_DWT && ddone) r_reg[idx_reg] <= dq;
            if (state_reg == ST_DIV && idx_reg == 3'd0 && det_reg == 32'sd0) begin
                sing_reg <= 1'b1;
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
                out_reg.singular <= sing_reg;
                if (op == amu_pkg::OP_LOAD) begin
                    h_reg[0] <= item_reg.operand_xx;
                    h_reg[1] <= item_reg.operand_xy;
                    h_reg[2] <= item_reg.operand_xz;
                    h_reg[3] <= item_reg.operand_yx;
                    h_reg[4] <= item_reg.operand_yy;
                    h_reg[5] <= item_reg.operand_yz;
                    out_reg.result_xx <= item_reg.operand_xx;
                    out_reg.result_xy <= item_reg.operand_xy;
                    out_reg.result_xz <= item_reg.operand_xz;
                    out_reg.result_yx <= item_reg.operand_yx;
                    out_reg.result_yy <= item_reg.operand_yy;
                    out_reg.result_yz <= item_reg.operand_yz;
                    out_reg.out_x <= '0;
                    out_reg.out_y <= '0;
                end else if (op == amu_pkg::OP_MUL || op == amu_pkg::OP_SCALE ||
                             op == amu_pkg::OP_INVERT) begin
                    for (int i = 0; i < 6; i++) begin
                        h_reg[i] <= sing_reg ? 32'sd0 : r_reg[i];
                    end
                    out_reg.result_xx <= sing_reg ? 32'sd0 : r_reg[0];
                    out_reg.result_xy <= sing_reg ? 32'sd0 : r_reg[1];
                    out_reg.result_xz <= sing_reg ? 32'sd0 : r_reg[2];
                    out_reg.result_yx <= sing_reg ? 32'sd0 : r_reg[3];
                    out_reg.result_yy <= sing_reg ? 32'sd0 : r_reg[4];
                    out_reg.result_yz <= sing_reg ? 32'sd0 : r_reg[5];
                    out_reg.out_x <= '0;
                    out_reg.out_y <= '0;
                end else begin
                    out_reg.result_xx <= h_reg[0];
                    out_reg.result_xy <= h_reg[1];
                    out_reg.result_xz <= h_reg[2];
                    out_reg.result_yx <= h_reg[3];
                    out_reg.result_yy <= h_reg[4];
                    out_reg.result_yz <= h_reg[5];
                    if (op == amu_pkg::OP_XFORM || op == amu_pkg::OP_SCALEP) begin
                        out_reg.out_x <= r_reg[0];
                        out_reg.out_y <= r_reg[1];
                    end else begin
                        out_reg.out_x <= '0;
                        out_reg.out_y <= '0;
                    end
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data = out_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped or changed while waiting");
    a_out_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_valid || m_ready)) |=> m_valid)
        else $error("result not presented");
endmodule
